>>> hdl/atipd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atipd_pkg;

  localparam int MAX_PAYLOAD_DEF = 1023;
  localparam int MAX_DIGITS_DEF  = 7;

  localparam int HEADER_LEN = 5;
  localparam int LENGTH_W   = 10;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_PAY  = 3'b100
  } phase_t;

  typedef struct packed {
    logic                valid;
    logic [7:0]          payload_byte;
    logic                last_of_frame;
    logic [LENGTH_W-1:0] frame_length;
  } result_t;

  function automatic logic [7:0] header_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = CH_PLUS;
      3'd1:    b = CH_I;
      3'd2:    b = CH_P;
      3'd3:    b = CH_D;
      3'd4:    b = CH_COMMA;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> hdl/at_ipd_frame_deframer.sv
// Path: an accepted byte is registered in the holding stage; the parse logic loads its
// result into the output register when that register is free (not valid, or not stalled).
// Throughput: one byte per cycle; a stalled output holds the pipe back.
// Reset: synchronous rst clears both stages and returns the parser to header hunting.
`timescale 1ns / 1ps
`default_nettype none

module at_ipd_frame_deframer
  import atipd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [7:0]          rx_byte,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [7:0]               payload_byte,
  output logic                     last_of_frame,
  output logic [LENGTH_W-1:0]      frame_length
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       out_free;
  logic       advance;
  result_t    res;

  assign out_free = !out_valid || !out_stall;
  assign advance  = held_valid && out_free;
  assign in_stall = held_valid && !out_free;

  atipd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .rx_byte (held_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid && out_free) begin
      payload_byte  <= res.payload_byte;
      last_of_frame <= res.last_of_frame;
      frame_length  <= res.frame_length;
    end
  end

endmodule

`default_nettype wire

>>> hdl/atipd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module atipd_parser
  import atipd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output result_t         res
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int DIG_W = $clog2(MAX_DIGITS + 1);
  localparam int MUL_W = LEN_W + 4;

  phase_t           phase, phase_next;
  logic [2:0]       header_position, header_position_next;
  logic [DIG_W-1:0] digit_count, digit_count_next;
  logic [LEN_W-1:0] length_accumulator, length_accumulator_next;
  logic [LEN_W-1:0] payload_count, payload_count_next;

  logic [MUL_W-1:0]         mul_val;
  logic [LEN_W+LENGTH_W-1:0] acc_ext;

  assign mul_val = (MUL_W'(length_accumulator) << 3) + (MUL_W'(length_accumulator) << 1)
                 + MUL_W'(rx_byte - CH_ZERO);
  assign acc_ext = {{LENGTH_W{1'b0}}, length_accumulator};

  always_comb begin
    phase_next              = phase;
    header_position_next    = header_position;
    digit_count_next        = digit_count;
    length_accumulator_next = length_accumulator;
    payload_count_next      = payload_count;
    res.valid               = 1'b0;
    res.payload_byte        = rx_byte;
    res.last_of_frame       = 1'b0;
    res.frame_length        = acc_ext[LENGTH_W-1:0];
    case (phase)
      PH_LEN: begin
        if (rx_byte inside {[CH_ZERO:CH_NINE]}) begin
          if (digit_count < DIG_W'(MAX_DIGITS)) begin
            if (mul_val > MUL_W'(MAX_PAYLOAD)) begin
              length_accumulator_next = LEN_W'(MAX_PAYLOAD);
            end else begin
              length_accumulator_next = mul_val[LEN_W-1:0];
            end
            digit_count_next = digit_count + DIG_W'(1);
          end
        end else if (rx_byte == CH_COLON) begin
          payload_count_next = '0;
          phase_next         = PH_PAY;
        end else begin
          phase_next = PH_HUNT;
        end
      end
      PH_PAY: begin
        if (payload_count < LEN_W'(MAX_PAYLOAD)) begin
          payload_count_next = payload_count + LEN_W'(1);
        end
        res.valid         = 1'b1;
        res.last_of_frame = (payload_count_next >= length_accumulator);
        if (res.last_of_frame) begin
          phase_next = PH_HUNT;
        end
      end
      default: begin
        if (rx_byte == header_byte(header_position)) begin
          if (header_position == 3'(HEADER_LEN - 1)) begin
            phase_next              = PH_LEN;
            header_position_next    = '0;
            digit_count_next        = '0;
            length_accumulator_next = '0;
          end else begin
            header_position_next = header_position + 3'd1;
          end
        end else begin
          header_position_next = '0;
          phase_next           = PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HUNT;
      header_position    <= '0;
      digit_count        <= '0;
      length_accumulator <= '0;
      payload_count      <= '0;
    end else if (step) begin
      phase              <= phase_next;
      header_position    <= header_position_next;
      digit_count        <= digit_count_next;
      length_accumulator <= length_accumulator_next;
      payload_count      <= payload_count_next;
    end
  end

endmodule

`default_nettype wire

>>> bench/at_ipd_frame_deframer_checker.sv
`timescale 1ns / 1ps

module at_ipd_frame_deframer_checker
  import atipd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic [7:0]          rx_byte,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [7:0]          payload_byte,
  input  logic                last_of_frame,
  input  logic [LENGTH_W-1:0] frame_length,
  output int                  mismatch_count,
  output int                  results_due
);

  localparam logic [HEADER_LEN*8-1:0] HEADER_SEQ = {CH_COMMA, CH_D, CH_P, CH_I, CH_PLUS};

  typedef struct packed {
    logic [7:0]          data;
    logic                last;
    logic [LENGTH_W-1:0] length;
  } payload_expect_t;

  payload_expect_t expected_payload_q[$];
  payload_expect_t oldest;

  phase_t      rx_phase;
  logic [2:0]  header_pos;
  logic [2:0]  digit_count;
  logic [10:0] length_acc;
  logic [9:0]  payload_count;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    int              acc_next;
    payload_expect_t item;
    case (rx_phase)
      PH_LEN: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          if (digit_count < MAX_DIGITS_DEF) begin
            acc_next = length_acc * 10 + (b - CH_ZERO);
            if (acc_next > MAX_PAYLOAD_DEF) acc_next = MAX_PAYLOAD_DEF;
            length_acc = acc_next[10:0];
            digit_count++;
          end
        end else if (b == CH_COLON) begin
          payload_count = '0;
          rx_phase = PH_PAY;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_PAY: begin
        if (payload_count < MAX_PAYLOAD_DEF) payload_count++;
        item.data   = b;
        item.last   = (payload_count >= length_acc);
        item.length = length_acc[LENGTH_W-1:0];
        expected_payload_q.push_back(item);
        if (item.last) rx_phase = PH_HUNT;
      end
      default: begin
        // drop the byte on a mismatch; it never restarts the header
        if (header_pos < HEADER_LEN && b == HEADER_SEQ[header_pos*8 +: 8]) begin
          header_pos++;
          if (header_pos == HEADER_LEN) begin
            rx_phase    = PH_LEN;
            header_pos  = '0;
            digit_count = '0;
            length_acc  = '0;
          end
        end else begin
          header_pos = '0;
          rx_phase   = PH_HUNT;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_phase      = PH_HUNT;
      header_pos    = '0;
      digit_count   = '0;
      length_acc    = '0;
      payload_count = '0;
      expected_payload_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_payload_q.size() == 0) begin
          report_mismatch($sformatf("unexpected payload item %02h", payload_byte));
        end else begin
          oldest = expected_payload_q.pop_front();
          if (payload_byte !== oldest.data)
            report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                      payload_byte, oldest.data));
          if (last_of_frame !== oldest.last)
            report_mismatch($sformatf("last_of_frame %b, expected %b (byte %02h)",
                                      last_of_frame, oldest.last, oldest.data));
          if (frame_length !== oldest.length)
            report_mismatch($sformatf("frame_length %0d, expected %0d",
                                      frame_length, oldest.length));
        end
      end
      if (in_valid && !in_stall) parse_rx_byte(rx_byte);
    end
    results_due = expected_payload_q.size();
  end

endmodule

>>> bench/at_ipd_frame_deframer_test.sv
`timescale 1ns / 1ps

module at_ipd_frame_deframer_test;
  import atipd_pkg::*;

  localparam int RANDOM_END  = 950;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          rx_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          payload_byte;
  logic                last_of_frame;
  logic [LENGTH_W-1:0] frame_length;

  int   mismatch_count;
  int   results_due;
  int   sent_items = 0;
  int   burst_left = 0;
  logic hold_off_req = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  at_ipd_frame_deframer uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .last_of_frame (last_of_frame),
    .frame_length  (frame_length)
  );

  at_ipd_frame_deframer_checker scoreboard (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .payload_byte   (payload_byte),
    .last_of_frame  (last_of_frame),
    .frame_length   (frame_length),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  function automatic logic [7:0] framing_char();
    logic [7:0] c;
    case ($urandom_range(0, 6))
      0:       c = CH_PLUS;
      1:       c = CH_I;
      2:       c = CH_P;
      3:       c = CH_D;
      4:       c = CH_COMMA;
      5:       c = CH_COLON;
      default: c = CH_ZERO + $urandom_range(0, 9);
    endcase
    return c;
  endfunction

  function automatic logic [7:0] stream_byte();
    logic [7:0] c;
    if ($urandom_range(0, 6) == 0) c = framing_char();
    else c = $urandom_range(0, 255);
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    burst_left--;
    sent_items++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_frame(input string digits);
    int value;
    int n;
    int i;
    value = 0;
    send_text({"+IPD,", digits, ":"});
    for (i = 0; i < digits.len() && i < MAX_DIGITS_DEF; i++) begin
      value = value * 10 + (digits[i] - CH_ZERO);
      if (value > MAX_PAYLOAD_DEF) value = MAX_PAYLOAD_DEF;
    end
    n = (value == 0) ? 1 : value;
    repeat (n) send_byte(stream_byte());
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_due == 0);
    burst_left = 0;
  endtask

  initial begin : receiver
    stall_mode_t mode;
    int          mode_left;
    int          hold_left;
    int          beat;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    beat      = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      beat++;
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= ((beat % 5) < 2);
        endcase
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("at_ipd_frame_deframer_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int         r;
    int         len;
    int         zeros;
    string      digits;
    logic [7:0] bad;
    logic       hold_done;
    logic       drain_done;
    string      hdr;
    hold_done     = 1'b0;
    drain_done    = 1'b0;
    hdr           = "+IPD,";

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    send_text("+IPD,0:");
    send_byte(8'h00);
    send_text("+IPD,00000009:");
    send_byte(8'hFF);
    send_text("++IPD,");
    wait_for_results();

    while (sent_items < RANDOM_END) begin
      r = $urandom_range(0, 99);
      if (!hold_done && sent_items > 300) begin
        hold_off_req = 1'b1;
        send_frame("64");
        hold_done = 1'b1;
      end else if (!drain_done && sent_items > 600) begin
        wait_for_results();
        drain_done = 1'b1;
      end else if (r < 60) begin
        len    = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
        zeros  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        digits = $sformatf("%0d", len);
        repeat (zeros) digits = {"0", digits};
        send_frame(digits);
      end else if (r < 66) begin
        digits = {"000000", $sformatf("%0d", $urandom_range(0, 9)),
                  $sformatf("%0d", $urandom_range(0, 99))};
        send_frame(digits);
      end else if (r < 70) begin
        send_frame("");
      end else if (r < 80) begin
        send_text({hdr, $sformatf("%0d", $urandom_range(0, 99))});
        do bad = $urandom_range(0, 255);
        while ((bad >= CH_ZERO && bad <= CH_NINE) || bad == CH_COLON);
        send_byte(bad);
      end else if (r < 90) begin
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) send_byte(hdr[i]);
        send_byte(stream_byte());
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(stream_byte());
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("at_ipd_frame_deframer_test: PASS");
    else $display("at_ipd_frame_deframer_test: FAIL");
    $finish;
  end

endmodule

>>> files.f
hdl/atipd_pkg.sv
hdl/atipd_parser.sv
hdl/at_ipd_frame_deframer.sv
bench/at_ipd_frame_deframer_checker.sv
bench/at_ipd_frame_deframer_test.sv
